// File: sv/sscc_pkg.sv
// Shared types and constants of the screen span occlusion clipper.
// Used by sscc_range_mem, sscc_walker and the top level; depends on nothing.
package sscc_pkg;

	localparam int MaxRangesDef = 32;
	localparam int MaxColumns   = 1024;
	localparam int ColW         = 10;
	localparam int RngW         = 11;
	localparam int WorkW        = 12;
	localparam logic [RngW-1:0] WidthReset = 11'd320;

	typedef logic [ColW-1:0]  col_t;
	typedef logic [RngW-1:0]  rng_t;
	typedef logic [WorkW-1:0] work_t;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_SOLID  = 2'd1;
	localparam logic [1:0] ACT_PASS   = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_END,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_MERGE,
		PH_DONE,
		PH_ABORT
	} phase_t;

	typedef struct packed {
		logic en;
		rng_t lo;
		rng_t hi;
	} rng_wr_t;

	typedef struct packed {
		col_t vis_start;
		col_t vis_end;
		logic fin;
		logic full;
	} piece_t;

endpackage

// File: sv/screen_span_occlusion_clipper_core.sv
// Top level of the screen span occlusion clipper: width register, output
// register, range store and span walker. Depends on sscc_pkg, sscc_range_mem, sscc_walker.
//
//  channel   valid       stall       payload
//  input     in_valid    in_stall    action, span_start, span_end
//  output    out_valid   out_stall   visible_start, visible_end, final_piece, list_full
//  config    cfg_wr_en   -           cfg_wr_data (screen_width)
//
// A clear, a reversed span or an unused action is handled in the idle state and
// starts no walk. For a span the walk reads one stored range per cycle, unless
// an output stall holds it, through the single read port of the range store.
// After reset the list is empty and the width is 320; the store needs no clearing.
// A stalled output word holds; the walker waits while a second piece is pending.
module screen_span_occlusion_clipper_core #(
	parameter int MAX_RANGES = sscc_pkg::MaxRangesDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  sscc_pkg::rng_t       cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  sscc_pkg::col_t       span_start,
	input  sscc_pkg::col_t       span_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sscc_pkg::col_t       visible_start,
	output sscc_pkg::col_t       visible_end,
	output logic                 final_piece,
	output logic                 list_full
);

	localparam int AW = $clog2(MAX_RANGES);

	sscc_pkg::rng_t    screen_width_q, width_clamped;
	logic              out_v_q, out_free, push;
	sscc_pkg::piece_t  push_piece, out_q;
	sscc_pkg::rng_wr_t wr;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic              rd_en;
	sscc_pkg::rng_t    rd_lo, rd_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= sscc_pkg::WidthReset;
		end else if (cfg_wr_en) begin
			screen_width_q <= cfg_wr_data;
		end
	end

	assign width_clamped = (32'(screen_width_q) > sscc_pkg::MaxColumns)
		? sscc_pkg::RngW'(sscc_pkg::MaxColumns) : screen_width_q;

	assign out_free = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_piece;
		end
	end

	assign out_valid     = out_v_q;
	assign visible_start = out_q.vis_start;
	assign visible_end   = out_q.vis_end;
	assign final_piece   = out_q.fin;
	assign list_full     = out_q.full;

	sscc_range_mem #(.MAX_RANGES(MAX_RANGES)) u_mem (
		.clk     (clk),
		.wr      (wr),
		.wr_addr (wr_addr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_lo   (rd_lo),
		.rd_hi   (rd_hi)
	);

	sscc_walker #(.MAX_RANGES(MAX_RANGES)) u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.span_start    (span_start),
		.span_end      (span_end),
		.width_clamped (width_clamped),
		.out_free      (out_free),
		.push          (push),
		.push_piece    (push_piece),
		.wr            (wr),
		.wr_addr       (wr_addr),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_lo         (rd_lo),
		.rd_hi         (rd_hi)
	);

endmodule

// File: sv/sscc_range_mem.sv
// Range store: one write port and one read port with registered read data.
// Depends on sscc_pkg for the range word types.
module sscc_range_mem #(
	parameter int MAX_RANGES = sscc_pkg::MaxRangesDef
) (
	input  logic                          clk,
	input  sscc_pkg::rng_wr_t             wr,
	input  logic [$clog2(MAX_RANGES)-1:0] wr_addr,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_RANGES)-1:0] rd_addr,
	output sscc_pkg::rng_t                rd_lo,
	output sscc_pkg::rng_t                rd_hi
);

	logic [2*sscc_pkg::RngW-1:0] mem_q [MAX_RANGES];
	logic [2*sscc_pkg::RngW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_addr] <= {wr.lo, wr.hi};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_lo = rd_q[2*sscc_pkg::RngW-1:sscc_pkg::RngW];
	assign rd_hi = rd_q[sscc_pkg::RngW-1:0];

endmodule

// File: sv/sscc_walker.sv
// Span walker: reads the stored ranges in order, emits uncovered pieces and
// rewrites, for a solid span, the merged list into the range store. Depends on sscc_pkg.
module sscc_walker #(
	parameter int MAX_RANGES = sscc_pkg::MaxRangesDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  sscc_pkg::col_t                span_start,
	input  sscc_pkg::col_t                span_end,
	input  sscc_pkg::rng_t                width_clamped,
	input  logic                          out_free,
	output logic                          push,
	output sscc_pkg::piece_t              push_piece,
	output sscc_pkg::rng_wr_t             wr,
	output logic [$clog2(MAX_RANGES)-1:0] wr_addr,
	output logic                          rd_en,
	output logic [$clog2(MAX_RANGES)-1:0] rd_addr,
	input  sscc_pkg::rng_t                rd_lo,
	input  sscc_pkg::rng_t                rd_hi
);

	localparam int AW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam logic [CW-1:0] CapCount = CW'(MAX_RANGES - 1);

	sscc_pkg::state_t state_q, state_d;
	sscc_pkg::phase_t phase_q, phase_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    k_q, k_d;
	logic [CW-1:0]    w_q, w_d;
	sscc_pkg::rng_t   cover_left_q, cover_left_d;
	sscc_pkg::rng_t   cover_right_q, cover_right_d;
	sscc_pkg::work_t  s_q, s_d, e_q, e_d;
	sscc_pkg::work_t  prev_hp1_q, prev_hp1_d;
	sscc_pkg::work_t  cur_lo_q, cur_lo_d, cur_hp1_q, cur_hp1_d;
	logic             solid_q, solid_d, cap_q, cap_d, g0_q, g0_d;
	logic             hold_v_q, hold_v_d;
	sscc_pkg::rng_t   hold_lo_q, hold_lo_d, hold_hi_q, hold_hi_d;
	logic             pend_v_q, pend_v_d;
	sscc_pkg::piece_t pend_q, pend_d;

	sscc_pkg::work_t ent_lo, ent_hp1, nxt_lo, ep1, a_col, pc_end, cur_hi, cl_w, s_in, e_in;
	logic            pc_valid, pc_full, busy, active;
	logic [CW-1:0]   k_n;

	always_comb begin
		ent_lo   = {1'b0, rd_lo};
		ent_hp1  = {1'b0, rd_hi} + 12'd1;
		nxt_lo   = (state_q == sscc_pkg::ST_END) ? {1'b0, cover_right_q} : ent_lo;
		ep1      = e_q + 12'd1;
		cur_hi   = cur_hp1_q - 12'd1;
		a_col    = (prev_hp1_q > s_q) ? prev_hp1_q : s_q;
		pc_valid = (a_col <= e_q) && (a_col < nxt_lo);
		pc_end   = (nxt_lo <= e_q) ? (nxt_lo - 12'd1) : e_q;
		pc_full  = solid_q && cap_q && (phase_q == sscc_pkg::PH_BEFORE) && (nxt_lo > ep1);
		busy     = pc_valid && pend_v_q && !out_free;
		active   = ((state_q == sscc_pkg::ST_WALK) || (state_q == sscc_pkg::ST_END)) && !busy;
		k_n      = k_q + 1'b1;
		cl_w     = {1'b0, cover_left_q};
		s_in     = {2'b00, span_start};
		e_in     = {2'b00, span_end};
	end

	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		count_d       = count_q;
		k_d           = k_q;
		w_d           = w_q;
		cover_left_d  = cover_left_q;
		cover_right_d = cover_right_q;
		s_d           = s_q;
		e_d           = e_q;
		prev_hp1_d    = prev_hp1_q;
		cur_lo_d      = cur_lo_q;
		cur_hp1_d     = cur_hp1_q;
		solid_d       = solid_q;
		cap_d         = cap_q;
		g0_d          = g0_q;
		hold_v_d      = hold_v_q;
		hold_lo_d     = hold_lo_q;
		hold_hi_d     = hold_hi_q;
		pend_v_d      = pend_v_q;
		pend_d        = pend_q;
		push          = 1'b0;
		push_piece    = pend_q;
		wr            = '0;
		rd_en         = 1'b0;
		rd_addr       = '0;
		in_stall      = (state_q != sscc_pkg::ST_IDLE);

		// emit the gap in front of the current entry, hold one piece back
		if (active && pc_valid) begin
			if (pend_v_q) begin
				push           = 1'b1;
				push_piece.fin = 1'b0;
			end
			pend_v_d         = 1'b1;
			pend_d.vis_start = a_col[sscc_pkg::ColW-1:0];
			pend_d.vis_end   = pc_end[sscc_pkg::ColW-1:0];
			pend_d.fin       = 1'b0;
			pend_d.full      = pc_full;
		end

		unique case (state_q)
			sscc_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (action == sscc_pkg::ACT_CLEAR) begin
						count_d       = '0;
						cover_left_d  = '0;
						cover_right_d = width_clamped;
					end else if ((action == sscc_pkg::ACT_SOLID || action == sscc_pkg::ACT_PASS)
							&& (span_start <= span_end)) begin
						s_d        = s_in;
						e_d        = e_in;
						solid_d    = (action == sscc_pkg::ACT_SOLID);
						cap_d      = (count_q == CapCount);
						prev_hp1_d = cl_w;
						w_d        = '0;
						k_d        = '0;
						hold_v_d   = 1'b0;
						g0_d       = (cl_w >= s_in);
						cur_lo_d   = s_in;
						if (cl_w >= s_in) begin
							cur_hp1_d = (cl_w > e_in + 12'd1) ? cl_w : (e_in + 12'd1);
							phase_d   = sscc_pkg::PH_MERGE;
						end else begin
							cur_hp1_d = e_in + 12'd1;
							phase_d   = sscc_pkg::PH_BEFORE;
						end
						if (count_q != '0) begin
							rd_en   = 1'b1;
							state_d = sscc_pkg::ST_WALK;
						end else begin
							state_d = sscc_pkg::ST_END;
						end
					end
				end
			end

			sscc_pkg::ST_WALK: begin
				if (active) begin
					unique case (phase_q)
						sscc_pkg::PH_BEFORE: begin
							if (ent_hp1 < s_q) begin
								wr  = '{en: solid_q, lo: rd_lo, hi: rd_hi};
								w_d = w_q + 1'b1;
							end else if (ent_lo > ep1) begin
								if (cap_q) begin
									phase_d = sscc_pkg::PH_ABORT;
								end else begin
									// insert the span, push this entry one slot up
									wr        = '{en: solid_q, lo: s_q[sscc_pkg::RngW-1:0],
										hi: e_q[sscc_pkg::RngW-1:0]};
									w_d       = w_q + 1'b1;
									hold_v_d  = 1'b1;
									hold_lo_d = rd_lo;
									hold_hi_d = rd_hi;
									phase_d   = sscc_pkg::PH_DONE;
								end
							end else begin
								cur_lo_d  = (ent_lo < s_q) ? ent_lo : s_q;
								cur_hp1_d = (ent_hp1 > ep1) ? ent_hp1 : ep1;
								phase_d   = sscc_pkg::PH_MERGE;
							end
						end
						sscc_pkg::PH_MERGE: begin
							if (ent_lo <= ep1) begin
								cur_hp1_d = (ent_hp1 > cur_hp1_q) ? ent_hp1 : cur_hp1_q;
							end else if (g0_q) begin
								if (solid_q) begin
									cover_left_d = cur_hp1_q[sscc_pkg::RngW-1:0];
								end
								wr      = '{en: solid_q, lo: rd_lo, hi: rd_hi};
								w_d     = w_q + 1'b1;
								phase_d = sscc_pkg::PH_DONE;
							end else begin
								wr        = '{en: solid_q, lo: cur_lo_q[sscc_pkg::RngW-1:0],
									hi: cur_hi[sscc_pkg::RngW-1:0]};
								w_d       = w_q + 1'b1;
								hold_v_d  = 1'b1;
								hold_lo_d = rd_lo;
								hold_hi_d = rd_hi;
								phase_d   = sscc_pkg::PH_DONE;
							end
						end
						sscc_pkg::PH_DONE: begin
							if (hold_v_q) begin
								wr        = '{en: solid_q, lo: hold_lo_q, hi: hold_hi_q};
								hold_lo_d = rd_lo;
								hold_hi_d = rd_hi;
							end else begin
								wr = '{en: solid_q, lo: rd_lo, hi: rd_hi};
							end
							w_d = w_q + 1'b1;
						end
						sscc_pkg::PH_ABORT: begin
						end
						default: begin
						end
					endcase
					prev_hp1_d = ent_hp1;
					k_d        = k_n;
					if (k_n < count_q) begin
						rd_en   = 1'b1;
						rd_addr = k_n[AW-1:0];
					end else begin
						state_d = sscc_pkg::ST_END;
					end
				end
			end

			sscc_pkg::ST_END: begin
				if (active) begin
					unique case (phase_q)
						sscc_pkg::PH_BEFORE: begin
							if ({1'b0, cover_right_q} > ep1) begin
								if (cap_q) begin
									phase_d = sscc_pkg::PH_ABORT;
								end else begin
									wr  = '{en: solid_q, lo: s_q[sscc_pkg::RngW-1:0],
										hi: e_q[sscc_pkg::RngW-1:0]};
									w_d = w_q + 1'b1;
								end
							end else if (solid_q && s_q < {1'b0, cover_right_q}) begin
								cover_right_d = s_q[sscc_pkg::RngW-1:0];
							end
						end
						sscc_pkg::PH_MERGE: begin
							if ({1'b0, cover_right_q} <= ep1) begin
								if (g0_q) begin
									// guards meet: the whole screen is covered
									if (solid_q) begin
										cover_left_d = cover_right_q;
									end
									w_d = '0;
								end else if (solid_q && cur_lo_q < {1'b0, cover_right_q}) begin
									cover_right_d = cur_lo_q[sscc_pkg::RngW-1:0];
								end
							end else if (g0_q) begin
								if (solid_q) begin
									cover_left_d = cur_hp1_q[sscc_pkg::RngW-1:0];
								end
							end else begin
								wr  = '{en: solid_q, lo: cur_lo_q[sscc_pkg::RngW-1:0],
									hi: cur_hi[sscc_pkg::RngW-1:0]};
								w_d = w_q + 1'b1;
							end
						end
						sscc_pkg::PH_DONE: begin
							if (hold_v_q) begin
								wr  = '{en: solid_q, lo: hold_lo_q, hi: hold_hi_q};
								w_d = w_q + 1'b1;
							end
						end
						sscc_pkg::PH_ABORT: begin
						end
						default: begin
						end
					endcase
					if (solid_q && phase_q != sscc_pkg::PH_ABORT
							&& phase_d != sscc_pkg::PH_ABORT) begin
						count_d = w_d;
					end
					state_d = sscc_pkg::ST_FLUSH;
				end
			end

			sscc_pkg::ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = sscc_pkg::ST_IDLE;
				end else if (out_free) begin
					push           = 1'b1;
					push_piece.fin = 1'b1;
					pend_v_d       = 1'b0;
					state_d        = sscc_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = sscc_pkg::ST_IDLE;
			end
		endcase
	end

	assign wr_addr = w_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sscc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= sscc_pkg::PH_BEFORE;
			count_q       <= '0;
			cover_left_q  <= '0;
			cover_right_q <= (32'(sscc_pkg::WidthReset) > sscc_pkg::MaxColumns)
				? sscc_pkg::RngW'(sscc_pkg::MaxColumns) : sscc_pkg::WidthReset;
			pend_v_q      <= 1'b0;
			hold_v_q      <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			count_q       <= count_d;
			cover_left_q  <= cover_left_d;
			cover_right_q <= cover_right_d;
			pend_v_q      <= pend_v_d;
			hold_v_q      <= hold_v_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q        <= k_d;
		w_q        <= w_d;
		s_q        <= s_d;
		e_q        <= e_d;
		prev_hp1_q <= prev_hp1_d;
		cur_lo_q   <= cur_lo_d;
		cur_hp1_q  <= cur_hp1_d;
		solid_q    <= solid_d;
		cap_q      <= cap_d;
		g0_q       <= g0_d;
		hold_lo_q  <= hold_lo_d;
		hold_hi_q  <= hold_hi_d;
		pend_q     <= pend_d;
	end

endmodule
